>>> design/cte_pkg.sv
// Shared types and codes for the character translate engine.
`default_nettype none
package cte_pkg;

  localparam int CP_BITS       = 21;
  localparam int KIND_BITS     = 2;
  localparam int FUNC_BITS     = 2;
  localparam int MCOUNT_BITS   = 16;
  localparam int DEPTH_DEFAULT = 256;
  localparam int COUNT_DEFAULT = 16;
  localparam int ADDR_BITS     = 4;
  localparam int DATA_BITS     = 32;

  localparam logic [FUNC_BITS-1:0] FN_CLEAR     = 2'd0;
  localparam logic [FUNC_BITS-1:0] FN_APPEND    = 2'd1;
  localparam logic [FUNC_BITS-1:0] FN_TRANSLATE = 2'd2;

  localparam logic [KIND_BITS-1:0] KIND_CHAR   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_KEEP   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_DELETE = 2'd2;

  localparam logic [1:0] REG_COMPLEMENT = 2'd0;
  localparam logic [1:0] REG_DELETE     = 2'd1;
  localparam logic [1:0] REG_SQUASH     = 2'd2;

  // One transaction as it moves along the cell chain.
  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [CP_BITS-1:0]   code;
    logic                 last;
    logic                 found;
    logic [KIND_BITS-1:0] kind;
    logic [CP_BITS-1:0]   repl;
    logic [KIND_BITS-1:0] tail_kind;
    logic [CP_BITS-1:0]   tail_repl;
  } item_t;

  typedef struct packed {
    logic complement_mode;
    logic delete_mode;
    logic squash_mode;
  } cfg_t;

  typedef struct packed {
    logic                   emit;
    logic [CP_BITS-1:0]     out_char;
    logic                   matched;
    logic [MCOUNT_BITS-1:0] match_count;
    logic                   status;
  } res_t;

endpackage
`default_nettype wire

>>> design/cte_cell.sv
// One table cell: holds a single entry and passes each transaction on.
`default_nettype none
module cte_cell
  import cte_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT,
  parameter int IDX         = 0,
  localparam int TW         = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          valid_in,
  input  wire item_t         item_in,
  input  wire logic [TW-1:0] total_in,
  output      logic          valid_out,
  output      item_t         item_out,
  output      logic [TW-1:0] total_out
);

  localparam logic [TW-1:0] MY_IDX  = TW'(IDX);
  localparam logic [TW-1:0] MY_NEXT = TW'(IDX + 1);

  logic [CP_BITS-1:0]   src;
  logic [CP_BITS-1:0]   repl;
  logic [KIND_BITS-1:0] kind;
  item_t                item_next;
  logic                 live;

  assign live = MY_IDX < total_in;

  always_comb begin
    item_next = item_in;
    if (item_in.func == FN_TRANSLATE && live) begin
      if (!item_in.found && src == item_in.code) begin
        item_next.found = 1'b1;
        item_next.kind  = kind;
        item_next.repl  = repl;
      end
      // The highest loaded entry supplies the complement replacement.
      if (total_in == MY_NEXT) begin
        item_next.tail_kind = kind;
        item_next.tail_repl = repl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_out  <= item_next;
      total_out <= total_in;
      if (valid_in && item_in.func == FN_APPEND && total_in == MY_IDX) begin
        src  <= item_in.code;
        repl <= item_in.repl;
        kind <= item_in.kind;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/cte_tail.sv
// Result stage: resolves the replacement, squash and match count.
`default_nettype none
module cte_tail
  import cte_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT,
  parameter int COUNT_BITS  = COUNT_DEFAULT,
  localparam int TW         = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid_in,
  input  wire item_t         item,
  input  wire logic [TW-1:0] total,
  input  wire cfg_t          cfg,
  input  wire logic          out_stall,
  output      logic          adv,
  output      logic          out_valid,
  output      res_t          res
);

  localparam logic [TW-1:0] FULL = TW'(TABLE_DEPTH);

  logic [COUNT_BITS-1:0]    running;
  logic [COUNT_BITS-1:0]    running_next;
  logic [CP_BITS-1:0]       prev_out;
  logic                     prev_valid;
  logic                     match;
  logic [KIND_BITS-1:0]     sel_kind;
  logic [CP_BITS-1:0]       sel_repl;
  logic [CP_BITS-1:0]       result;
  logic [COUNT_BITS+15:0]   wide_count;
  logic                     squashed;
  res_t                     res_next;

  assign adv = !out_valid || !out_stall;

  always_comb begin
    match    = 1'b0;
    sel_kind = KIND_KEEP;
    sel_repl = '0;
    if (!cfg.complement_mode) begin
      if (item.found) begin
        match    = 1'b1;
        sel_kind = item.kind;
        sel_repl = item.repl;
      end
    end else if (!item.found) begin
      match = 1'b1;
      if (cfg.delete_mode) begin
        sel_kind = KIND_DELETE;
      end else if (total != '0) begin
        sel_kind = item.tail_kind;
        sel_repl = item.tail_repl;
      end
    end
    result = (sel_kind == KIND_CHAR) ? sel_repl : item.code;

    running_next = running;
    if (match && running != '1) begin
      running_next = running + COUNT_BITS'(1);
    end
    wide_count = {16'b0, running_next};
    squashed   = cfg.squash_mode && prev_valid && prev_out == result;

    res_next = '0;
    case (item.func)
      FN_APPEND: begin
        res_next.status = (total == FULL);
      end
      FN_TRANSLATE: begin
        res_next.matched     = match;
        res_next.match_count = (wide_count > (COUNT_BITS+16)'(17'h0FFFF))
                               ? 16'hFFFF : wide_count[15:0];
        if (!match) begin
          res_next.emit     = 1'b1;
          res_next.out_char = item.code;
        end else if (sel_kind != KIND_DELETE && !squashed) begin
          res_next.emit     = 1'b1;
          res_next.out_char = result;
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      running    <= '0;
      prev_out   <= '0;
      prev_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= valid_in;
      if (valid_in && item.func == FN_TRANSLATE) begin
        prev_out <= result;
        if (item.last) begin
          running    <= '0;
          prev_valid <= 1'b0;
        end else begin
          running    <= running_next;
          prev_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

>>> design/character_translate_engine.sv
// Top level of the character translate engine: head, cell chain and result stage.
//
// Input channel: in_valid/in_stall with func, code, repl_kind, repl_char and last.
// A transaction is taken at a rising edge with in_valid high and in_stall low.
// func clears the table, appends an entry or translates one code point.
// Output channel: out_valid/out_stall with emit, out_char, matched, match_count
// and status; exactly one result per input transaction, in order.
// Each transaction walks a chain of TABLE_DEPTH registered cells, one entry per
// cell, then a registered result stage. The chain is fully pipelined, so one
// transaction is accepted every cycle while the output is not stalled.
// When out_stall holds a result, the whole chain freezes and in_stall is raised
// in the same cycle; nothing is lost or reordered.
// Reset empties the table count, clears the match count and the previous
// character, and resets the three mode registers; table entries are not
// cleared and no clearing pass is needed.
// Mode registers sit on the APB port at 0x0, 0x4 and 0x8; the user must write
// them only while the engine is idle; the block itself does not enforce this.
`default_nettype none
module character_translate_engine
  import cte_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT,
  parameter int COUNT_BITS  = COUNT_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire logic [FUNC_BITS-1:0]   func,
  input  wire logic [CP_BITS-1:0]     code,
  input  wire logic [KIND_BITS-1:0]   repl_kind,
  input  wire logic [CP_BITS-1:0]     repl_char,
  input  wire logic                   last,
  output      logic                   out_valid,
  input  wire logic                   out_stall,
  output      logic                   emit,
  output      logic [CP_BITS-1:0]     out_char,
  output      logic                   matched,
  output      logic [MCOUNT_BITS-1:0] match_count,
  output      logic                   status,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_BITS-1:0]   paddr,
  input  wire logic [DATA_BITS-1:0]   pwdata,
  output      logic [DATA_BITS-1:0]   prdata,
  output      logic                   pready
);

  localparam int TW = $clog2(TABLE_DEPTH + 1);
  localparam logic [TW-1:0] FULL = TW'(TABLE_DEPTH);

  cfg_t            cfg;
  logic [TW-1:0]   total;
  logic            adv;
  logic            accept;
  item_t           head_item;
  res_t            res;

  item_t           chain_item  [TABLE_DEPTH+1];
  logic [TW-1:0]   chain_total [TABLE_DEPTH+1];
  logic            chain_valid [TABLE_DEPTH+1];

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_COMPLEMENT: cfg.complement_mode <= pwdata[0];
        REG_DELETE:     cfg.delete_mode     <= pwdata[0];
        REG_SQUASH:     cfg.squash_mode     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COMPLEMENT: prdata = DATA_BITS'(cfg.complement_mode);
      REG_DELETE:     prdata = DATA_BITS'(cfg.delete_mode);
      REG_SQUASH:     prdata = DATA_BITS'(cfg.squash_mode);
      default:        prdata = '0;
    endcase
  end

  // Head: keeps the entry count and tags each transaction with it.
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_comb begin
    head_item           = '0;
    head_item.func      = func;
    head_item.code      = code;
    head_item.last      = last;
    head_item.repl      = repl_char;
    head_item.kind      = (repl_kind == KIND_CHAR || repl_kind == KIND_DELETE)
                          ? repl_kind : KIND_KEEP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (accept) begin
      case (func)
        FN_CLEAR:  total <= '0;
        FN_APPEND: if (total != FULL) total <= total + TW'(1);
        default: ;
      endcase
    end
  end

  assign chain_item[0]  = head_item;
  assign chain_total[0] = total;
  assign chain_valid[0] = in_valid;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cte_cell #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IDX        (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .valid_in (chain_valid[g]),
      .item_in  (chain_item[g]),
      .total_in (chain_total[g]),
      .valid_out(chain_valid[g+1]),
      .item_out (chain_item[g+1]),
      .total_out(chain_total[g+1])
    );
  end

  cte_tail #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_tail (
    .clk      (clk),
    .rst      (rst),
    .valid_in (chain_valid[TABLE_DEPTH]),
    .item     (chain_item[TABLE_DEPTH]),
    .total    (chain_total[TABLE_DEPTH]),
    .cfg      (cfg),
    .out_stall(out_stall),
    .adv      (adv),
    .out_valid(out_valid),
    .res      (res)
  );

  assign emit        = res.emit;
  assign out_char    = res.out_char;
  assign matched     = res.matched;
  assign match_count = res.match_count;
  assign status      = res.status;

`ifndef SYNTHESIS
  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    total <= FULL)
    else $error("entry count ran past the table depth");

  a_refused_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !emit && !matched && match_count == '0)
    else $error("refused append produced character output");

  a_match_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && matched |-> match_count != '0)
    else $error("match reported with zero count");
`endif

endmodule
`default_nettype wire
